FILE: sv/rse_pkg.sv
// Shared constants, request and status codes, and control types for the stack engine.
package rse_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int WORD_BITS   = 64;
    localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
    localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_PUSH      = 3'd0,
        REQ_POP       = 3'd1,
        REQ_PEEK      = 3'd2,
        REQ_ROT_RIGHT = 3'd3,
        REQ_ROT_LEFT  = 3'd4,
        REQ_REVERSE   = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MOVE,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic move;
        logic respond;
    } rse_cmd_t;

    typedef struct packed {
        logic needs_move;
    } rse_stat_t;

endpackage

FILE: sv/rse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rse_datapath.sv
// Stack datapath: circular storage with a movable bottom and growth direction.
module rse_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rse_pkg::rse_cmd_t                     cmd,
    output rse_pkg::rse_stat_t                    stat,
    input  logic [2:0]                            req_type,
    input  logic [rse_pkg::WORD_BITS-1:0]         push_value,
    output logic [rse_pkg::WORD_BITS-1:0]         read_value,
    output logic [1:0]                            status,
    output logic [rse_pkg::COUNT_BITS-1:0]        entry_count,
    output logic                                  is_empty
);

    localparam int AW = rse_pkg::ADDR_BITS;
    localparam int CW = rse_pkg::COUNT_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(rse_pkg::STACK_DEPTH);
    localparam logic [CW:0]   DEPTH_EXT  = (CW + 1)'(rse_pkg::STACK_DEPTH);

    // Entries live in a ring: logical entry k sits k places from the bottom,
    // counted upward or downward depending on the direction bit.
    function automatic logic [AW-1:0] wrap_fwd(input logic [AW-1:0] b,
                                               input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW + 1)'(b) + (CW + 1)'(k);
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_bwd(input logic [AW-1:0] b,
                                               input logic [CW-1:0] k);
        logic [CW:0] diff;
        if ((CW + 1)'(b) >= (CW + 1)'(k))
        begin
            diff = (CW + 1)'(b) - (CW + 1)'(k);
        end
        else
        begin
            diff = (CW + 1)'(b) + DEPTH_EXT - (CW + 1)'(k);
        end
        return diff[AW-1:0];
    endfunction

    rse_pkg::req_t                 req_reg;
    logic [rse_pkg::WORD_BITS-1:0] word_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 base_reg, base_next;
    logic                          dir_reg, dir_next;
    rse_pkg::status_t              status_reg, status_next;

    logic [rse_pkg::WORD_BITS-1:0] read_value_reg;
    rse_pkg::status_t              status_out_reg;
    logic [CW-1:0]                 entry_count_reg;
    logic                          is_empty_reg;

    logic [CW-1:0]                 top_idx;
    logic [AW-1:0]                 top_addr, end_addr, below_addr, next_base_addr;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [rse_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;
    logic                          is_rotate;

    assign top_idx        = count_reg - CW'(1);
    assign top_addr       = dir_reg ? wrap_bwd(base_reg, top_idx)
                                    : wrap_fwd(base_reg, top_idx);
    assign end_addr       = dir_reg ? wrap_bwd(base_reg, count_reg)
                                    : wrap_fwd(base_reg, count_reg);
    assign below_addr     = dir_reg ? wrap_fwd(base_reg, CW'(1))
                                    : wrap_bwd(base_reg, CW'(1));
    assign next_base_addr = dir_reg ? wrap_bwd(base_reg, CW'(1))
                                    : wrap_fwd(base_reg, CW'(1));

    assign is_rotate       = (req_reg == rse_pkg::REQ_ROT_RIGHT) ||
                             (req_reg == rse_pkg::REQ_ROT_LEFT);
    assign stat.needs_move = is_rotate && (count_reg > CW'(1));

    // The read is issued every cycle; only the word read during the issue
    // cycle is used, in the move or respond cycle that follows.
    assign mem_raddr = (req_reg == rse_pkg::REQ_ROT_LEFT) ? base_reg : top_addr;

    always_comb
    begin
        count_next  = count_reg;
        base_next   = base_reg;
        dir_next    = dir_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = end_addr;
        mem_wdata   = word_reg;
        if (cmd.issue)
        begin
            status_next = rse_pkg::STAT_OK;
            case (req_reg)
                rse_pkg::REQ_PUSH:
                begin
                    if (count_reg == FULL_COUNT)
                    begin
                        status_next = rse_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                rse_pkg::REQ_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = rse_pkg::STAT_UNDERFLOW;
                    end
                    else
                    begin
                        count_next = top_idx;
                    end
                end
                rse_pkg::REQ_PEEK:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = rse_pkg::STAT_UNDERFLOW;
                    end
                end
                rse_pkg::REQ_REVERSE:
                begin
                    // The old top becomes the bottom and the stack grows the other way.
                    if (count_reg > CW'(1))
                    begin
                        base_next = top_addr;
                        dir_next  = ~dir_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.move)
        begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            if (req_reg == rse_pkg::REQ_ROT_RIGHT)
            begin
                // The top word goes just below the bottom, which becomes the new bottom.
                mem_waddr = below_addr;
                base_next = below_addr;
            end
            else
            begin
                // The bottom word goes just above the top; the bottom moves up one.
                mem_waddr = end_addr;
                base_next = next_base_addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            base_reg   <= '0;
            dir_reg    <= 1'b0;
            status_reg <= rse_pkg::STAT_OK;
        end
        else
        begin
            count_reg  <= count_next;
            base_reg   <= base_next;
            dir_reg    <= dir_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= rse_pkg::req_t'(req_type);
            word_reg <= push_value;
        end
        if (cmd.respond)
        begin
            if (((req_reg == rse_pkg::REQ_POP) || (req_reg == rse_pkg::REQ_PEEK)) &&
                (status_reg == rse_pkg::STAT_OK))
            begin
                read_value_reg <= mem_rdata;
            end
            else
            begin
                read_value_reg <= '0;
            end
            status_out_reg  <= status_reg;
            entry_count_reg <= count_reg;
            is_empty_reg    <= (count_reg == '0);
        end
    end

    rse_ram #(
        .WIDTH(rse_pkg::WORD_BITS),
        .DEPTH(rse_pkg::STACK_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign read_value  = read_value_reg;
    assign status      = status_out_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond stack depth");

    a_base_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(base_reg) < DEPTH_EXT)
        else $error("bottom pointer outside the store");

    a_full_push_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && (req_reg == rse_pkg::REQ_PUSH) && (count_reg == FULL_COUNT))
        |=> ((status_reg == rse_pkg::STAT_OVERFLOW) && (count_reg == FULL_COUNT)))
        else $error("push on a full stack not refused");

    a_count_only_on_issue: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.issue |=> $stable(count_reg))
        else $error("entry count changed outside the issue cycle");

endmodule

FILE: sv/rse_ctrl.sv
// Request sequencer: steps each request through issue, optional move and respond.
module rse_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output rse_pkg::rse_cmd_t   cmd,
    input  rse_pkg::rse_stat_t  stat
);

    rse_pkg::state_t state_reg, state_next;
    logic            done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rse_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rse_pkg::ST_ISSUE;
                end
            end
            rse_pkg::ST_ISSUE:
            begin
                state_next = stat.needs_move ? rse_pkg::ST_MOVE : rse_pkg::ST_RESPOND;
            end
            rse_pkg::ST_MOVE:
            begin
                state_next = rse_pkg::ST_RESPOND;
            end
            rse_pkg::ST_RESPOND:
            begin
                state_next = rse_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        busy      = 1'b1;
        done_next = 1'b0;
        case (state_reg)
            rse_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            rse_pkg::ST_ISSUE:
            begin
                cmd.issue = 1'b1;
            end
            rse_pkg::ST_MOVE:
            begin
                cmd.move = 1'b1;
            end
            rse_pkg::ST_RESPOND:
            begin
                cmd.respond = 1'b1;
                done_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rse_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

    a_accept_issues: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == rse_pkg::ST_ISSUE))
        else $error("accepted word not issued");

    a_done_after_respond: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == rse_pkg::ST_RESPOND))
        else $error("result strobe without a respond cycle");

    a_move_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rse_pkg::ST_MOVE) |-> ($past(state_reg) == rse_pkg::ST_ISSUE))
        else $error("move cycle not preceded by issue");

endmodule

FILE: sv/rotating_stack_engine_core.sv
// Top level of the rotating stack engine: sequencer plus stack datapath.
//
// Usage: drive req_type and push_value and raise start; the word is taken at
// a rising edge where start is high and busy is low. Each request returns one
// result word on read_value, status, entry_count and is_empty, valid for
// exactly one cycle while done is high. The receiver cannot hold results off.
// Each request passes through issue and respond steps; a rotation of more than
// one entry adds a move step between them, since the moved entry needs a read
// and a write-back through the store's single read port and registered read
// data. done coincides with busy going low, so a new request can be accepted
// in the done cycle, independent of how many entries are held. Rotate and
// reverse are constant time because entries sit in a ring with a movable
// bottom pointer and a growth-direction bit.
// Reset (rst_n low, asynchronous) empties the stack and returns to idle; the
// store contents themselves are not cleared and need no clearing pass.
module rotating_stack_engine_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            req_type,
    input  logic [rse_pkg::WORD_BITS-1:0]         push_value,
    output logic                                  done,
    output logic [rse_pkg::WORD_BITS-1:0]         read_value,
    output logic [1:0]                            status,
    output logic [rse_pkg::COUNT_BITS-1:0]        entry_count,
    output logic                                  is_empty
);

    rse_pkg::rse_cmd_t  cmd;
    rse_pkg::rse_stat_t stat;

    rse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    rse_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .push_value  (push_value),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

endmodule

FILE: dv/rotating_stack_engine_core_tb.sv
// Self-checking testbench for the rotating stack engine core with a shadow stack predictor.
module rotating_stack_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Request codes the block leaves unused; they must behave as no-ops.
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int WORD_TARGET = 1550;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [2:0]                    kind;
        logic [rse_pkg::WORD_BITS-1:0] word;
    } stack_request_t;

    typedef struct {
        logic [rse_pkg::WORD_BITS-1:0]  read_value;
        rse_pkg::status_t               status;
        logic [rse_pkg::COUNT_BITS-1:0] entry_count;
        logic                           is_empty;
    } stack_reply_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [2:0]                     req_type = rse_pkg::REQ_PUSH;
    logic [rse_pkg::WORD_BITS-1:0]  push_value = '0;
    logic                           done;
    logic [rse_pkg::WORD_BITS-1:0]  read_value;
    logic [1:0]                     status;
    logic [rse_pkg::COUNT_BITS-1:0] entry_count;
    logic                           is_empty;

    stack_request_t requests_todo[$];
    stack_reply_t   replies_due[$];

    // Shadow copy of the stack; entry 0 is the bottom.
    logic [rse_pkg::WORD_BITS-1:0] shadow_stack [rse_pkg::STACK_DEPTH];
    int                            shadow_fill = 0;

    int planned_fill = 0;
    int words_planned = 0;
    int words_accepted = 0;
    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;

    rotating_stack_engine_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .push_value  (push_value),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    always #5 clk = ~clk;

    // Applies one request to the shadow stack and queues the reply it owes.
    task automatic run_stack_op(input logic [2:0] kind,
                                input logic [rse_pkg::WORD_BITS-1:0] word);
        stack_reply_t                  reply;
        logic [rse_pkg::WORD_BITS-1:0] held;
        int                            n;
        begin
            n = shadow_fill;
            reply.read_value = '0;
            reply.status = rse_pkg::STAT_OK;
            case (kind)
                rse_pkg::REQ_PUSH:
                begin
                    if (n >= rse_pkg::STACK_DEPTH)
                        reply.status = rse_pkg::STAT_OVERFLOW;
                    else
                    begin
                        shadow_stack[n] = word;
                        n++;
                    end
                end
                rse_pkg::REQ_POP:
                begin
                    if (n == 0)
                        reply.status = rse_pkg::STAT_UNDERFLOW;
                    else
                    begin
                        n--;
                        reply.read_value = shadow_stack[n];
                    end
                end
                rse_pkg::REQ_PEEK:
                begin
                    if (n == 0)
                        reply.status = rse_pkg::STAT_UNDERFLOW;
                    else
                        reply.read_value = shadow_stack[n-1];
                end
                rse_pkg::REQ_ROT_RIGHT:
                begin
                    if (n > 1)
                    begin
                        held = shadow_stack[n-1];
                        for (int i = n - 1; i > 0; i--)
                            shadow_stack[i] = shadow_stack[i-1];
                        shadow_stack[0] = held;
                    end
                end
                rse_pkg::REQ_ROT_LEFT:
                begin
                    if (n > 1)
                    begin
                        held = shadow_stack[0];
                        for (int i = 0; i + 1 < n; i++)
                            shadow_stack[i] = shadow_stack[i+1];
                        shadow_stack[n-1] = held;
                    end
                end
                rse_pkg::REQ_REVERSE:
                begin
                    for (int i = 0; i < n / 2; i++)
                    begin
                        held = shadow_stack[i];
                        shadow_stack[i] = shadow_stack[n-1-i];
                        shadow_stack[n-1-i] = held;
                    end
                end
                default:
                begin
                end
            endcase
            shadow_fill = n;
            reply.entry_count = rse_pkg::COUNT_BITS'(n);
            reply.is_empty = (n == 0);
            replies_due.insert(replies_due.size(), reply);
        end
    endtask

    // Queues a request and tracks the fill level it will leave behind.
    task automatic add_request(input logic [2:0] kind,
                               input logic [rse_pkg::WORD_BITS-1:0] word);
        stack_request_t req;
        begin
            req.kind = kind;
            req.word = word;
            requests_todo.insert(requests_todo.size(), req);
            words_planned++;
            if (kind == rse_pkg::REQ_PUSH && planned_fill < rse_pkg::STACK_DEPTH)
                planned_fill++;
            else if (kind == rse_pkg::REQ_POP && planned_fill > 0)
                planned_fill--;
        end
    endtask

    function automatic logic [rse_pkg::WORD_BITS-1:0] pick_word();
        logic [rse_pkg::WORD_BITS-1:0] one_hot;
        begin
            one_hot = rse_pkg::WORD_BITS'(1) << $urandom_range(0, rse_pkg::WORD_BITS - 1);
            case ($urandom_range(0, 9))
                0: pick_word = '0;
                1: pick_word = '1;
                2: pick_word = one_hot;
                3: pick_word = ~one_hot;
                default: pick_word = {$urandom, $urandom};
            endcase
        end
    endfunction

    function automatic logic [2:0] pick_op(input int push_pct, input int pop_pct);
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                pick_op = rse_pkg::REQ_PUSH;
            else if (roll < push_pct + pop_pct)
                pick_op = rse_pkg::REQ_POP;
            else
                case ($urandom_range(0, 10))
                    0, 1, 2: pick_op = rse_pkg::REQ_PEEK;
                    3, 4:    pick_op = rse_pkg::REQ_ROT_RIGHT;
                    5, 6:    pick_op = rse_pkg::REQ_ROT_LEFT;
                    7, 8:    pick_op = rse_pkg::REQ_REVERSE;
                    9:       pick_op = REQ_SPARE_6;
                    default: pick_op = REQ_SPARE_7;
                endcase
        end
    endfunction

    // Sender: bursts of back-to-back words separated by random gaps.
    always @(posedge clk)
    begin
        stack_request_t req;
        logic           next_start;
        logic           ready_for_next;
        if (rst_n)
        begin
            next_start = start;
            ready_for_next = !start;
            if (start && !busy)
            begin
                run_stack_op(req_type, push_value);
                words_accepted++;
                ready_for_next = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                           : $urandom_range(0, 4);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
            end
            if (ready_for_next)
            begin
                next_start = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (requests_todo.size() > 0)
                begin
                    req = requests_todo.pop_front();
                    req_type <= req.kind;
                    push_value <= req.word;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Result checker: every done pulse must match the oldest outstanding reply.
    always @(posedge clk)
    begin
        stack_reply_t want;
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected word: read_value %h status %0d count %0d empty %0b",
                         $time, read_value, status, entry_count, is_empty);
                error_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, read_value);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    error_count++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, entry_count);
                    error_count++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty expected %0b actual %0b",
                             $time, want.is_empty, is_empty);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        // Directed: empty-stack corners, single-entry no-ops, small rotations, spare codes.
        add_request(rse_pkg::REQ_POP, '0);
        add_request(rse_pkg::REQ_PEEK, '1);
        add_request(rse_pkg::REQ_ROT_RIGHT, '0);
        add_request(rse_pkg::REQ_ROT_LEFT, '0);
        add_request(rse_pkg::REQ_REVERSE, '0);
        add_request(rse_pkg::REQ_PUSH, '1);
        add_request(rse_pkg::REQ_ROT_RIGHT, '0);
        add_request(rse_pkg::REQ_ROT_LEFT, '0);
        add_request(rse_pkg::REQ_REVERSE, '0);
        add_request(rse_pkg::REQ_PEEK, '0);
        add_request(rse_pkg::REQ_PUSH, '0);
        add_request(rse_pkg::REQ_PUSH, 64'h0123_4567_89ab_cdef);
        add_request(rse_pkg::REQ_ROT_RIGHT, '0);
        add_request(rse_pkg::REQ_PEEK, '0);
        add_request(rse_pkg::REQ_ROT_LEFT, '0);
        add_request(rse_pkg::REQ_PEEK, '0);
        add_request(rse_pkg::REQ_REVERSE, '0);
        add_request(REQ_SPARE_6, '1);
        add_request(REQ_SPARE_7, '1);
        add_request(rse_pkg::REQ_POP, '0);
        add_request(rse_pkg::REQ_POP, '0);
        add_request(rse_pkg::REQ_POP, '0);
        add_request(rse_pkg::REQ_POP, '0);

        // Shallow mix that keeps returning to the empty stack.
        repeat (250)
            add_request(pick_op(35, 30), pick_word());
        // Fill to capacity, then work the full stack including refused pushes.
        while (planned_fill < rse_pkg::STACK_DEPTH)
            add_request(pick_op(88, 4), pick_word());
        repeat (40)
            add_request(pick_op(45, 10), pick_word());
        while (words_planned < WORD_TARGET)
            add_request(pick_op(30, 45), pick_word());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted < words_planned)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/rse_pkg.sv
sv/rse_ram.sv
sv/rse_datapath.sv
sv/rse_ctrl.sv
sv/rotating_stack_engine_core.sv
dv/rotating_stack_engine_core_tb.sv
